[design/anp_pkg.sv]
// package for the ascii number parser: shared types, character codes and defaults
// used by anp_char_class and ascii_number_parser_core
package anp_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int OUT_WIDTH       = 32;

	localparam logic [63:0] BAD_PATTERN = 64'hdead_beef;

	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;

	typedef enum logic [1:0] {
		POS_FIRST  = 2'd0,
		POS_SECOND = 2'd1,
		POS_BODY   = 2'd2
	} pos_t;

	typedef struct packed {
		logic       is_digit;
		logic       is_hex;
		logic       is_minus;
		logic       is_zero;
		logic       is_x;
		logic [3:0] nib;
	} char_class_t;

endpackage

[design/ascii_number_parser_core.sv]
// ascii number parser, top level
// checks decimal and 0x hex forms of a character stream; uses anp_pkg and anp_char_class
//
// usage:
//   characters enter on the char channel (char_valid, char_stall, ch, last), one per
//   transaction; last marks the final character of a string. every string gives one
//   transaction on the res channel (res_valid, res_stall, value, valid_res, was_hex).
//   an invalid string gives valid_res = 0 and the 0xdeadbeef pattern at VALUE_WIDTH.
// throughput and pipeline:
//   one character per cycle while char_stall is low. a character goes into an input
//   register, the accumulator update and the result select run combinationally behind
//   it, and the result register follows: the result is loaded into it when the final
//   character leaves the input register. the ten-times multiply is a shift and add.
// reset:
//   arst_n clears both registers' valid flags and puts the parser at the start of a
//   string.
// stall:
//   a held result keeps its output register; the input register keeps taking
//   non-final characters, and only a final character waits, which raises char_stall.
module ascii_number_parser_core #(
	parameter int VALUE_WIDTH = anp_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                char_valid,
	output logic                                char_stall,
	input  logic [7:0]                          ch,
	input  logic                                last,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic signed [anp_pkg::OUT_WIDTH-1:0] value,
	output logic                                valid_res,
	output logic                                was_hex
);

	localparam logic [VALUE_WIDTH-1:0] BAD_W = VALUE_WIDTH'(anp_pkg::BAD_PATTERN);
	localparam logic [anp_pkg::OUT_WIDTH-1:0] BAD_OUT =
		anp_pkg::OUT_WIDTH'(64'(BAD_W));

	logic                   valid_s1;
	logic [7:0]             ch_s1;
	logic                   last_s1;
	logic                   adv_s1;
	logic                   load_s1;
	logic                   out_load;

	anp_pkg::pos_t          pos_q;
	logic                   dec_poss_q;
	logic                   hex_poss_q;
	logic                   neg_q;
	logic                   digit_seen_q;
	logic [VALUE_WIDTH-1:0] dec_acc_q;
	logic [VALUE_WIDTH-1:0] hex_acc_q;

	anp_pkg::pos_t          pos_n;
	logic                   dec_poss_n;
	logic                   hex_poss_n;
	logic                   neg_n;
	logic                   digit_seen_n;
	logic [VALUE_WIDTH-1:0] dec_acc_n;
	logic [VALUE_WIDTH-1:0] hex_acc_n;
	logic [VALUE_WIDTH-1:0] dec_val;
	logic [VALUE_WIDTH-1:0] res_w;
	logic                   dec_ok;
	logic                   hex_ok;

	anp_pkg::char_class_t   cls;

	anp_char_class u_class (
		.ch  (ch_s1),
		.cls (cls)
	);

	// flow control
	assign out_load   = valid_s1 && last_s1 && (!res_valid || !res_stall);
	assign adv_s1     = valid_s1 && (!last_s1 || !res_valid || !res_stall);
	assign char_stall = valid_s1 && !adv_s1;
	assign load_s1    = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	// per-character update of both forms
	always_comb begin
		dec_poss_n   = dec_poss_q;
		hex_poss_n   = hex_poss_q;
		neg_n        = neg_q;
		digit_seen_n = digit_seen_q;
		dec_acc_n    = dec_acc_q;
		hex_acc_n    = hex_acc_q;
		pos_n        = pos_q;

		if (pos_q == anp_pkg::POS_FIRST && cls.is_minus) begin
			neg_n = 1'b1;
		end else if (cls.is_digit) begin
			dec_acc_n = VALUE_WIDTH'({dec_acc_q[VALUE_WIDTH-4:0], 3'b000})
				+ VALUE_WIDTH'({dec_acc_q[VALUE_WIDTH-2:0], 1'b0})
				+ VALUE_WIDTH'(cls.nib);
			digit_seen_n = 1'b1;
		end else begin
			dec_poss_n = 1'b0;
		end

		case (pos_q)
			anp_pkg::POS_FIRST: begin
				if (!cls.is_zero) hex_poss_n = 1'b0;
				pos_n = anp_pkg::POS_SECOND;
			end
			anp_pkg::POS_SECOND: begin
				if (!cls.is_x) hex_poss_n = 1'b0;
				pos_n = anp_pkg::POS_BODY;
			end
			default: begin
				if (cls.is_hex) begin
					hex_acc_n = {hex_acc_q[VALUE_WIDTH-5:0], cls.nib};
				end else begin
					hex_poss_n = 1'b0;
				end
			end
		endcase

		dec_ok  = dec_poss_n && digit_seen_n;
		hex_ok  = hex_poss_n && (pos_q == anp_pkg::POS_BODY);
		dec_val = neg_n ? (VALUE_WIDTH'(0) - dec_acc_n) : dec_acc_n;
		if (dec_ok) begin
			res_w = dec_val;
		end else if (hex_ok) begin
			res_w = hex_acc_n;
		end else begin
			res_w = BAD_W;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= anp_pkg::POS_FIRST;
			dec_poss_q   <= 1'b1;
			hex_poss_q   <= 1'b1;
			neg_q        <= 1'b0;
			digit_seen_q <= 1'b0;
			dec_acc_q    <= '0;
			hex_acc_q    <= '0;
		end else if (adv_s1) begin
			if (last_s1) begin
				pos_q        <= anp_pkg::POS_FIRST;
				dec_poss_q   <= 1'b1;
				hex_poss_q   <= 1'b1;
				neg_q        <= 1'b0;
				digit_seen_q <= 1'b0;
				dec_acc_q    <= '0;
				hex_acc_q    <= '0;
			end else begin
				pos_q        <= pos_n;
				dec_poss_q   <= dec_poss_n;
				hex_poss_q   <= hex_poss_n;
				neg_q        <= neg_n;
				digit_seen_q <= digit_seen_n;
				dec_acc_q    <= dec_acc_n;
				hex_acc_q    <= hex_acc_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (out_load) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			value     <= anp_pkg::OUT_WIDTH'(64'(res_w));
			valid_res <= dec_ok || hex_ok;
			was_hex   <= !dec_ok && hex_ok;
		end
	end

	a_hex_implies_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(was_hex && !valid_res))
		else $error("was_hex set on an invalid result");

	a_bad_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !valid_res) |-> (value == BAD_OUT))
		else $error("invalid result without the bad pattern");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> (valid_s1 && last_s1 && res_valid && res_stall))
		else $error("char channel stalled without a held final character");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (pos_q == anp_pkg::POS_FIRST && dec_poss_q
			&& hex_poss_q && !neg_q && !digit_seen_q))
		else $error("parser not back at string start after final character");

	a_result_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> res_valid)
		else $error("final character did not produce a result");

endmodule

[design/anp_char_class.sv]
// character classifier for the ascii number parser
// decodes one ascii character into digit, hex, sign and prefix flags and a nibble; uses anp_pkg
module anp_char_class (
	input  logic [7:0]           ch,
	output anp_pkg::char_class_t cls
);

	localparam logic [3:0] NIB_LETTER_ADJ = 4'd9;

	always_comb begin
		cls          = '0;
		cls.is_minus = (ch == anp_pkg::CH_MINUS);
		cls.is_zero  = (ch == anp_pkg::CH_ZERO);
		cls.is_x     = (ch == anp_pkg::CH_LO_X);
		if (ch inside {[anp_pkg::CH_ZERO:anp_pkg::CH_NINE]}) begin
			cls.is_digit = 1'b1;
			cls.is_hex   = 1'b1;
			cls.nib      = ch[3:0];
		end else if (ch inside {[anp_pkg::CH_LO_A:anp_pkg::CH_LO_F],
				[anp_pkg::CH_UP_A:anp_pkg::CH_UP_F]}) begin
			cls.is_hex = 1'b1;
			cls.nib    = ch[3:0] + NIB_LETTER_ADJ;
		end
	end

endmodule
